FILE: rtl/mpbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbs_pkg: shared types and constants of the byte scrubber
// Pattern table, window slot layout and the front queue sizing.
// ----------------------------------------------------------------------------
package mpbs_pkg;

  localparam int unsigned NUM_PATTERNS    = 10;
  localparam int unsigned MAX_PATTERN_LEN = 15;

  // Skip counter holds up to MAX_PATTERN_LEN - 1
  localparam int unsigned SKIP_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

  // Front queue: power-of-two depth
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Pattern lengths, table order. Entries beyond the table are zero (pass-through).
  localparam int unsigned PAT_LEN [NUM_PATTERNS] = '{
    8, 11, 12, 11, 12, 15, 9, 11, 9, 9
  };

  // Pattern text, first character in the most significant used byte, so the
  // final character sits in bits [7:0] and matches the newest window slot.
  localparam logic [MAX_PATTERN_LEN*8-1:0] PAT_TEXT [NUM_PATTERNS] = '{
    120'h4C49424652494441,
    120'h667269646_12D6167656E74,
    120'h667269646_12D676164676574,
    120'h667269646_15F6167656E74,
    120'h667269646_12D736572766572,
    120'h72652E667269646_12E736572766572,
    120'h667269646_13A727063,
    120'h67756D2D6A732D6C6F6F70,
    120'h47756D536372697074,
    120'h6C696E6A6563746F72
  };

  typedef struct packed {
    logic bypass;
    logic last;
    logic is_real;
  } tag_t;

  typedef struct packed {
    logic [7:0] data;
    tag_t       tag;
    logic       mark;
  } slot_t;

  // Head of the front queue as seen by the back end
  typedef struct packed {
    logic  valid;
    slot_t item;
  } q_head_t;

endpackage

FILE: rtl/mpbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbs_front: input acceptance and classification
// Turns each item into a tagged window slot and queues it for the back end.
// ----------------------------------------------------------------------------
module mpbs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 in_valid_i,
  input  logic                 buf_last_i,
  input  logic                 bypass_i,
  output mpbs_pkg::q_head_t    head_o,
  input  logic                 pop_i
);

  mpbs_pkg::slot_t                    mem_q [mpbs_pkg::FIFO_DEPTH];
  logic [mpbs_pkg::PTR_W-1:0]         wr_q, wr_d, rd_q, rd_d;
  logic [mpbs_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  mpbs_pkg::slot_t                    cls;
  logic                               push;

  // Pads carry an empty tag and a zero byte
  always_comb begin
    cls             = '0;
    if (in_valid_i) begin
      cls.data        = data_byte_i;
      cls.tag.is_real = 1'b1;
      cls.tag.last    = buf_last_i;
      cls.tag.bypass  = bypass_i;
    end
  end

  assign item_ready_o = (cnt_q != mpbs_pkg::CNT_W'(mpbs_pkg::FIFO_DEPTH));
  assign push         = item_valid_i && item_ready_o;

  assign wr_d  = push  ? wr_q + 1'b1 : wr_q;
  assign rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
  assign cnt_d = cnt_q + mpbs_pkg::CNT_W'(push) - mpbs_pkg::CNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];

endmodule

FILE: rtl/mpbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpbs_back: pattern cell chain and result register
// One shift window per pattern; all cells step together on each queued item.
// ----------------------------------------------------------------------------
module mpbs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpbs_pkg::q_head_t    head_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic                 out_scrubbed_o
);

  // ch[s] feeds cell s; ch[NUM_PATTERNS] is the slot leaving the chain
  mpbs_pkg::slot_t ch [mpbs_pkg::NUM_PATTERNS+1];
  logic            step;
  logic            exit_real;
  logic            res_valid_q, res_valid_d;
  mpbs_pkg::slot_t res_q;

  assign ch[0]     = head_i.item;
  assign exit_real = ch[mpbs_pkg::NUM_PATTERNS].tag.is_real;

  // Step on a queued item unless a real byte exits while the result is stuck
  assign step  = head_i.valid && (!exit_real || !res_valid_q || res_ready_i);
  assign pop_o = step;

  for (genvar s = 0; s < mpbs_pkg::NUM_PATTERNS; s++) begin : g_cell
    localparam int unsigned L = mpbs_pkg::PAT_LEN[s];
    if (L == 0) begin : g_thru
      assign ch[s+1] = ch[s];
    end else begin : g_win
      mpbs_pkg::slot_t              win_q [L];
      mpbs_pkg::slot_t              win_d [L];
      mpbs_pkg::slot_t              shifted [L];
      logic [mpbs_pkg::SKIP_W-1:0]  skip_q, skip_d;
      logic                         hit;

      always_comb begin
        shifted[0] = ch[s];
        for (int p = 1; p < L; p++) begin
          shifted[p] = win_q[p-1];
        end
      end

      // Whole window real, not bypass, no buffer end except in the newest slot
      always_comb begin
        hit = 1'b1;
        for (int p = 0; p < L; p++) begin
          if (!shifted[p].tag.is_real || shifted[p].tag.bypass ||
              ((p > 0) && shifted[p].tag.last) ||
              (shifted[p].data != mpbs_pkg::PAT_TEXT[s][p*8 +: 8])) begin
            hit = 1'b0;
          end
        end
      end

      always_comb begin
        win_d  = win_q;
        skip_d = skip_q;
        if (step) begin
          win_d = shifted;
          if (skip_q != '0) begin
            skip_d = skip_q - 1'b1;
          end else if (hit) begin
            for (int p = 0; p < L; p++) begin
              win_d[p].data = 8'h00;
              win_d[p].mark = 1'b1;
            end
            skip_d = mpbs_pkg::SKIP_W'(L - 1);
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          skip_q <= '0;
          for (int p = 0; p < L; p++) begin
            win_q[p] <= '0;
          end
        end else begin
          skip_q <= skip_d;
          win_q  <= win_d;
        end
      end

      assign ch[s+1] = win_q[L-1];
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (step && exit_real) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && exit_real) begin
      res_q <= ch[mpbs_pkg::NUM_PATTERNS];
    end
  end

  assign res_valid_o    = res_valid_q;
  assign out_byte_o     = res_q.data;
  assign out_last_o     = res_q.tag.last;
  assign out_scrubbed_o = res_q.mark;

endmodule

FILE: rtl/multi_pattern_byte_scrubber.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle, sustained while both sides keep up.
// Latency: an item is queued at acceptance and stepped in from the queue head; its
// result is registered on the step of the 107th item after it (summed pattern lengths),
// so pad items must follow the last real byte to flush it out.
// Reset: asynchronous, active low; clears every window slot, skip counter, queue and
// result valid at once, with no clearing pass.
// ----------------------------------------------------------------------------
// multi_pattern_byte_scrubber: streaming multi-pattern zeroing filter
// Front end classifies and queues items; back end runs the pattern cell chain.
// ----------------------------------------------------------------------------
module multi_pattern_byte_scrubber (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        in_valid_i,
  input  logic        buf_last_i,
  input  logic        bypass_i,
  // result channel
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        out_scrubbed_o
);

  // Queue head handed from the front end to the cell chain. The back end pops
  // it on every step, so the two sides stall independently: the front keeps
  // accepting while the queue has room even if a result is waiting.
  mpbs_pkg::q_head_t head;
  logic              pop;

  // Front end: pad items become empty slots, real bytes get real/last/bypass
  // tags, then everything goes into a two-entry queue.
  mpbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_i),
    .item_ready_o (item_ready_o),
    .data_byte_i  (data_byte_i),
    .in_valid_i   (in_valid_i),
    .buf_last_i   (buf_last_i),
    .bypass_i     (bypass_i),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back end: every cell shifts by one slot per step, then compares its whole
  // window in parallel against its pattern. A hit zeroes and marks the window
  // and arms the skip counter so matches never overlap. Real bytes leaving
  // the last cell land in the result register; pads leave silently.
  mpbs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .out_scrubbed_o (out_scrubbed_o)
  );

endmodule
